// ===== design/slab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator package
// Shared widths, defaults, operation codes and controller states.
// ----------------------------------------------------------------------------
package slab_pkg;

  // Fixed field widths.
  localparam int unsigned ADDR_W = 18;
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned FUNC_W = 2;

  // Link memory: one entry per four-byte slot, holding {valid, next address}.
  localparam int unsigned LINK_W     = ADDR_W + 1;
  localparam int unsigned LINK_DEPTH = 65536;
  localparam int unsigned LINK_AW    = 16;

  // Default configuration.
  localparam int unsigned MAX_PAGES_DEF  = 64;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned PTR_BYTES      = 4;
  localparam logic [SIZE_W-1:0] SLOT_SIZE_RESET = 12'd4;

  // Operation codes carried in the input tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_DESTROY = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

endpackage

// ===== design/slab_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab generic RAM
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module slab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/slab_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab objects-per-page divider
// Restoring divider, one quotient bit per cycle, giving (PAGE_BYTES-4)/size.
// ----------------------------------------------------------------------------
module slab_div #(
  parameter int unsigned PAGE_BYTES = slab_pkg::PAGE_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [slab_pkg::SIZE_W-1:0]     divisor_i,
  output logic                            busy_o,
  output logic [$clog2(PAGE_BYTES)-1:0]   quot_o
);

  localparam int unsigned DW = $clog2(PAGE_BYTES);
  localparam int unsigned CW = $clog2(DW);
  localparam logic [DW-1:0] DIVIDEND = DW'(PAGE_BYTES - slab_pkg::PTR_BYTES);
  // After reset the size is the pointer size, so the quotient is known.
  localparam logic [DW-1:0] QUOT_RESET =
    DW'((PAGE_BYTES - slab_pkg::PTR_BYTES) / slab_pkg::PTR_BYTES);

  logic                        busy_q, busy_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [slab_pkg::SIZE_W-1:0] div_q, div_d;
  logic [slab_pkg::SIZE_W-1:0] rem_q, rem_d;
  logic [DW-1:0]               quot_q, quot_d;
  logic [slab_pkg::SIZE_W:0]   trial;
  logic                        fits;

  assign trial = {rem_q, DIVIDEND[cnt_q]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW - 1);
      div_d  = divisor_i;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits the size width.
      rem_d  = fits ? slab_pkg::SIZE_W'(trial - {1'b0, div_q})
                    : slab_pkg::SIZE_W'(trial);
      quot_d = {quot_q[DW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= slab_pkg::SLOT_SIZE_RESET;
      rem_q  <= '0;
      quot_q <= QUOT_RESET;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      div_q  <= div_d;
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ===== design/slab_free_list_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab free-list allocator core
// Fixed-size object allocator with a LIFO free list held in a link RAM.
// ----------------------------------------------------------------------------
// Each input word carries an operation in tuser (allocate, free, destroy or
// no-op) and returns exactly one result word: the allocated address in tdata
// and the success flag in tuser. Free, destroy and allocations served from a
// fresh page register their result in the next cycle; an allocation that
// pops the free list sends its result from the pop state, as the next link
// is read from the single-port link RAM, whose read is registered. A write
// of the object size recomputes the objects per page in a bit-serial divider,
// holding off input words while it is busy. The link RAM is not cleared after
// reset or destroy: only entries written by a free are ever read back.
module slab_free_list_allocator_core #(
  parameter int unsigned MAX_PAGES  = slab_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = slab_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [17:0] obj_addr, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] func

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] addr, rest zero
  output logic [0:0]  m_axis_tuser,   // [0] ok

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i      // object size in bytes
);

  localparam int unsigned AW = slab_pkg::ADDR_W;
  localparam int unsigned SW = slab_pkg::SIZE_W;
  localparam int unsigned LW = $clog2(PAGE_BYTES);
  localparam int unsigned PW = $clog2(MAX_PAGES + 1);
  localparam logic [AW-1:0] PAGE_STEP = AW'(PAGE_BYTES);
  localparam logic [PW-1:0] PAGES_MAX = PW'(MAX_PAGES);
  localparam logic [SW-1:0] PTR_SIZE  = SW'(slab_pkg::PTR_BYTES);

  slab_pkg::state_e state_q, state_d;

  logic [SW-1:0] slot_size_q, slot_size_d;
  logic          head_valid_q, head_valid_d;
  logic [AW-1:0] head_addr_q, head_addr_d;
  logic [PW-1:0] pages_q, pages_d;
  logic [AW-1:0] open_base_q, open_base_d;
  logic [AW-1:0] next_base_q, next_base_d;
  logic [AW-1:0] fresh_next_q, fresh_next_d;
  logic [LW-1:0] fresh_left_q, fresh_left_d;
  logic          m_valid_q, m_valid_d;
  logic [AW-1:0] m_addr_q, m_addr_d;
  logic          m_ok_q, m_ok_d;

  logic          accept;
  logic          cfg_write;
  logic [SW-1:0] stride;
  logic [SW-1:0] cfg_stride;
  logic          div_busy;
  logic [LW-1:0] per_page;
  slab_pkg::func_e func;
  logic [AW-1:0] in_addr;

  logic                          ram_en;
  logic                          ram_we;
  logic [slab_pkg::LINK_AW-1:0]  ram_addr;
  logic [slab_pkg::LINK_W-1:0]   ram_wdata;
  logic [slab_pkg::LINK_W-1:0]   ram_rdata;

  assign func      = slab_pkg::func_e'(s_axis_tuser);
  assign in_addr   = s_axis_tdata[AW-1:0];
  assign cfg_write = cfg_valid_i & cfg_ready_o;
  assign stride    = (slot_size_q < PTR_SIZE) ? PTR_SIZE : slot_size_q;
  assign cfg_stride = (cfg_data_i < PTR_SIZE) ? PTR_SIZE : cfg_data_i;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == slab_pkg::ST_IDLE) && !div_busy
                         && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Pushes write the old head into the freed slot; pops read the head's link.
  assign ram_we    = accept && (func == slab_pkg::FUNC_FREE);
  assign ram_en    = ram_we || (accept && (func == slab_pkg::FUNC_ALLOC) && head_valid_q);
  assign ram_addr  = ram_we ? in_addr[AW-1:2] : head_addr_q[AW-1:2];
  assign ram_wdata = {head_valid_q, head_addr_q};

  slab_ram #(
    .WIDTH (slab_pkg::LINK_W),
    .DEPTH (slab_pkg::LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  slab_div #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_write),
    .divisor_i (cfg_stride),
    .busy_o    (div_busy),
    .quot_o    (per_page)
  );

  always_comb begin
    state_d      = state_q;
    slot_size_d  = cfg_write ? cfg_data_i : slot_size_q;
    head_valid_d = head_valid_q;
    head_addr_d  = head_addr_q;
    pages_d      = pages_q;
    open_base_d  = open_base_q;
    next_base_d  = next_base_q;
    fresh_next_d = fresh_next_q;
    fresh_left_d = fresh_left_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_addr_d     = m_addr_q;
    m_ok_d       = m_ok_q;

    case (state_q)
      slab_pkg::ST_IDLE: begin
        if (accept) begin
          m_valid_d = 1'b1;
          m_addr_d  = '0;
          m_ok_d    = 1'b1;
          case (func)
            slab_pkg::FUNC_ALLOC: begin
              if (head_valid_q) begin
                // Result is sent once the link word comes back.
                m_valid_d = 1'b0;
                state_d   = slab_pkg::ST_POP;
              end else if (fresh_left_q != '0) begin
                m_addr_d     = open_base_q + fresh_next_q;
                fresh_next_d = fresh_next_q + AW'(stride);
                fresh_left_d = fresh_left_q - 1'b1;
              end else if ((pages_q >= PAGES_MAX) || (per_page == '0)) begin
                m_ok_d = 1'b0;
              end else begin
                m_addr_d     = next_base_q;
                open_base_d  = next_base_q;
                next_base_d  = next_base_q + PAGE_STEP;
                pages_d      = pages_q + 1'b1;
                fresh_next_d = AW'(stride);
                fresh_left_d = per_page - 1'b1;
              end
            end
            slab_pkg::FUNC_FREE: begin
              head_valid_d = 1'b1;
              head_addr_d  = in_addr;
            end
            slab_pkg::FUNC_DESTROY: begin
              head_valid_d = 1'b0;
              head_addr_d  = '0;
              pages_d      = '0;
              open_base_d  = '0;
              next_base_d  = '0;
              fresh_next_d = '0;
              fresh_left_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      slab_pkg::ST_POP: begin
        m_valid_d    = 1'b1;
        m_addr_d     = head_addr_q;
        m_ok_d       = 1'b1;
        head_valid_d = ram_rdata[AW];
        head_addr_d  = ram_rdata[AW-1:0];
        state_d      = slab_pkg::ST_IDLE;
      end
      default: begin
        state_d = slab_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= slab_pkg::ST_IDLE;
      slot_size_q  <= slab_pkg::SLOT_SIZE_RESET;
      head_valid_q <= 1'b0;
      head_addr_q  <= '0;
      pages_q      <= '0;
      open_base_q  <= '0;
      next_base_q  <= '0;
      fresh_next_q <= '0;
      fresh_left_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_size_q  <= slot_size_d;
      head_valid_q <= head_valid_d;
      head_addr_q  <= head_addr_d;
      pages_q      <= pages_d;
      open_base_q  <= open_base_d;
      next_base_q  <= next_base_d;
      fresh_next_q <= fresh_next_d;
      fresh_left_q <= fresh_left_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_addr_q <= m_addr_d;
    m_ok_q   <= m_ok_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_addr_q};
  assign m_axis_tuser  = m_ok_q;

endmodule

// ===== dv/slab_free_list_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab free-list allocator core testbench
// Drives allocate, free, destroy and no-op words under several object sizes
// and checks every result word against its typed expectation or a cycle-free
// predictor. The test opens with a table of directed words, then runs random
// phases of mostly well-formed alloc/free traffic with random back-pressure.
// ----------------------------------------------------------------------------
module slab_free_list_allocator_core_tb;

  localparam int unsigned MAX_PAGES   = slab_pkg::MAX_PAGES_DEF;
  localparam int unsigned PAGE_BYTES  = slab_pkg::PAGE_BYTES_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_WORDS = 148;
  localparam int unsigned N_PHASES    = 9;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // Typed rows carry their own expectation; the others use the predictor.
  localparam logic TYPED = 1'b1;
  localparam logic PRED  = 1'b0;

  typedef struct packed {
    row_kind_e       kind;
    logic [11:0]     size;
    slab_pkg::func_e func;
    logic [17:0]     addr;
    logic            chk;
    logic [17:0]     exp_addr;
    logic            exp_ok;
  } dir_row_t;

  typedef struct packed {
    logic [11:0] size;
    logic        rnd_size;
    logic [6:0]  alloc_pct;
    logic        wipe;
    logic        hold;
    logic        calm;
  } phase_t;

  typedef struct packed {
    logic [17:0] addr;
    logic        ok;
  } slab_result_t;

  localparam dir_row_t DIR_ROWS [28] = '{
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, TYPED, 18'h00000, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h3FFFF, TYPED, 18'h00004, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_FREE,    18'h3FFFF, TYPED, 18'h00000, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_FREE,    18'h00000, TYPED, 18'h00000, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, TYPED, 18'h00000, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, TYPED, 18'h3FFFF, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, TYPED, 18'h00008, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_NOP,     18'h2AAAA, TYPED, 18'h00000, 1'b1},
    // Two frees that share one link entry, then pops through the alias.
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_FREE,    18'h15555, PRED,  18'h00000, 1'b0},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_FREE,    18'h15556, PRED,  18'h00000, 1'b0},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, TYPED, 18'h15556, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, PRED,  18'h00000, 1'b0},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, PRED,  18'h00000, 1'b0},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_DESTROY, 18'h3FFFF, TYPED, 18'h00000, 1'b1},
    // A page too small for one object fails straight away.
    '{ROW_CFG,  12'd4093, slab_pkg::FUNC_NOP,     18'h00000, PRED,  18'h00000, 1'b0},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, TYPED, 18'h00000, 1'b0},
    '{ROW_CFG,  12'd4092, slab_pkg::FUNC_NOP,     18'h00000, PRED,  18'h00000, 1'b0},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, TYPED, 18'h00000, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, TYPED, 18'h01000, 1'b1},
    // Sizes below four are rounded up to four.
    '{ROW_CFG,  12'd0,    slab_pkg::FUNC_NOP,     18'h00000, PRED,  18'h00000, 1'b0},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, TYPED, 18'h02000, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, TYPED, 18'h02004, 1'b1},
    // The open page keeps its count while the stride changes.
    '{ROW_CFG,  12'd4095, slab_pkg::FUNC_NOP,     18'h00000, PRED,  18'h00000, 1'b0},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, PRED,  18'h00000, 1'b0},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_ALLOC,   18'h00000, PRED,  18'h00000, 1'b0},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_FREE,    18'h20000, TYPED, 18'h00000, 1'b1},
    '{ROW_ITEM, 12'd0,    slab_pkg::FUNC_DESTROY, 18'h00000, TYPED, 18'h00000, 1'b1},
    '{ROW_CFG,  12'd4,    slab_pkg::FUNC_NOP,     18'h00000, PRED,  18'h00000, 1'b0}
  };

  localparam phase_t PHASES [N_PHASES] = '{
    '{12'd4,    1'b0, 7'd55, 1'b0, 1'b0, 1'b0},
    '{12'd4092, 1'b0, 7'd85, 1'b1, 1'b0, 1'b0},
    '{12'd0,    1'b0, 7'd50, 1'b0, 1'b1, 1'b0},
    '{12'd100,  1'b0, 7'd55, 1'b1, 1'b0, 1'b1},
    '{12'd4095, 1'b0, 7'd40, 1'b0, 1'b0, 1'b0},
    '{12'd2048, 1'b0, 7'd80, 1'b1, 1'b0, 1'b0},
    '{12'd1,    1'b0, 7'd50, 1'b0, 1'b0, 1'b0},
    '{12'hAAA,  1'b0, 7'd70, 1'b1, 1'b0, 1'b0},
    '{12'd4,    1'b1, 7'd55, 1'b0, 1'b0, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [17:0] obj_addr, rest zero
  logic [1:0]  s_axis_tuser;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [17:0] addr, rest zero
  logic [0:0]  m_axis_tuser;   // [0] ok
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [11:0] cfg_data_i;

  // Expectation travelling beside a directed word.
  logic        word_chk;
  logic [17:0] word_exp_addr;
  logic        word_exp_ok;

  logic calm;
  logic hold_off_req;
  int   errors;

  // Predicted allocator state.
  logic [11:0] slot_size    = slab_pkg::SLOT_SIZE_RESET;
  logic        head_valid   = 1'b0;
  logic [17:0] head_addr    = '0;
  logic [18:0] links [slab_pkg::LINK_DEPTH];
  logic [6:0]  pages_used   = '0;
  logic [10:0] fresh_left   = '0;
  // Kept wide: after a size change mid-page the offset may run past the page.
  int unsigned fresh_next   = 0;

  slab_result_t expected_results [$];
  logic [17:0]  live_objs [$];

  slab_free_list_allocator_core #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic slab_result_t slab_predict(input slab_pkg::func_e f,
                                                input logic [17:0] a);
    slab_result_t res;
    logic [18:0]  lnk;
    int unsigned  stride;
    int unsigned  per_page;
    res    = '{addr: '0, ok: 1'b1};
    stride = (slot_size < slab_pkg::PTR_BYTES) ? slab_pkg::PTR_BYTES : slot_size;
    case (f)
      slab_pkg::FUNC_ALLOC: begin
        if (head_valid) begin
          lnk        = links[head_addr[17:2]];
          res.addr   = head_addr;
          head_valid = lnk[18];
          head_addr  = lnk[17:0];
        end else if (fresh_left != 0) begin
          res.addr   = 18'((int'(pages_used) - 1) * PAGE_BYTES + fresh_next);
          fresh_next = fresh_next + stride;
          fresh_left = fresh_left - 1'b1;
        end else begin
          per_page = (PAGE_BYTES - slab_pkg::PTR_BYTES) / stride;
          if (pages_used >= MAX_PAGES || per_page == 0) begin
            res.ok = 1'b0;
          end else begin
            res.addr   = 18'(pages_used * PAGE_BYTES);
            pages_used = pages_used + 1'b1;
            fresh_next = stride;
            fresh_left = 11'(per_page - 1);
          end
        end
      end
      slab_pkg::FUNC_FREE: begin
        links[a[17:2]] = {head_valid, head_addr};
        head_addr      = a;
        head_valid     = 1'b1;
      end
      slab_pkg::FUNC_DESTROY: begin
        head_valid = 1'b0;
        head_addr  = '0;
        pages_used = '0;
        fresh_next = 0;
        fresh_left = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Inputs are sampled here in one process, so a result word can never be
  // compared before the expectation of the word that caused it is queued.
  always @(posedge clk_i) begin : monitor
    slab_result_t pred;
    slab_result_t want;
    int unsigned  quiet_cycles;
    logic         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        slot_size = cfg_data_i;
        moved     = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = slab_predict(slab_pkg::func_e'(s_axis_tuser), s_axis_tdata[17:0]);
        if (word_chk) begin
          expected_results.push_back('{addr: word_exp_addr, ok: word_exp_ok});
        end else begin
          expected_results.push_back(pred);
        end
        if (slab_pkg::func_e'(s_axis_tuser) == slab_pkg::FUNC_ALLOC && pred.ok) begin
          live_objs.push_back(pred.addr);
        end else if (slab_pkg::func_e'(s_axis_tuser) == slab_pkg::FUNC_DESTROY) begin
          live_objs.delete();
        end
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, addr %05h ok %0b", $time,
                   m_axis_tdata[17:0], m_axis_tuser[0]);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[17:0] !== want.addr) begin
            $display("%0t: addr expected %05h, actual %05h", $time, want.addr,
                     m_axis_tdata[17:0]);
            errors++;
          end
          if (m_axis_tuser[0] !== want.ok) begin
            $display("%0t: ok expected %0b, actual %0b", $time, want.ok, m_axis_tuser[0]);
            errors++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= rst_ni && (calm || $urandom_range(99) >= 16);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so the next word can follow without a gap.
  task automatic send_word(input slab_pkg::func_e f, input logic [17:0] a,
                           input logic chk, input logic [17:0] exp_addr,
                           input logic exp_ok);
    while (!calm && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {6'd0, a};
    word_chk      <= chk;
    word_exp_addr <= exp_addr;
    word_exp_ok   <= exp_ok;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // The size register is only written once every result word has drained.
  task automatic write_slot_size(input logic [11:0] sz);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sz;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    dir_row_t        row;
    slab_pkg::func_e f;
    logic [17:0]     a;
    logic [11:0]     sz;
    int unsigned     pick;
    int unsigned     idx;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = slab_pkg::FUNC_NOP;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = slab_pkg::SLOT_SIZE_RESET;
    word_chk      = 1'b0;
    word_exp_addr = '0;
    word_exp_ok   = 1'b0;
    calm          = 1'b0;
    hold_off_req  = 1'b0;
    errors        = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        write_slot_size(row.size);
      end else begin
        send_word(row.func, row.addr, row.chk, row.exp_addr, row.exp_ok);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      calm = PHASES[p].calm;
      sz   = PHASES[p].rnd_size ? 12'($urandom_range(4, 4092)) : PHASES[p].size;
      write_slot_size(sz);
      if (PHASES[p].wipe) begin
        send_word(slab_pkg::FUNC_DESTROY, 18'($urandom), 1'b0, '0, 1'b0);
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (PHASES[p].hold && n == 30) begin
          hold_off_req = 1'b1;
        end
        a = 18'($urandom);
        if ($urandom_range(99) < PHASES[p].alloc_pct) begin
          f = slab_pkg::FUNC_ALLOC;
        end else begin
          pick = $urandom_range(99);
          // Mostly return a live object; the rest is stray frees and noise.
          if (pick < 80 && live_objs.size() != 0) begin
            f   = slab_pkg::FUNC_FREE;
            idx = $urandom_range(live_objs.size() - 1);
            a   = live_objs[idx];
            live_objs.delete(idx);
          end else if (pick < 92) begin
            f = slab_pkg::FUNC_FREE;
          end else if (pick < 98) begin
            f = slab_pkg::FUNC_NOP;
          end else begin
            f = slab_pkg::FUNC_DESTROY;
          end
        end
        send_word(f, a, 1'b0, '0, 1'b0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
